### src/blm_pkg.sv
// Shared constants for the battery level monitor.
package blm_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int MV_W     = 12;
	localparam int EVERY_W  = 8;
	localparam int STATE_W  = 2;
	localparam int EVENT_W  = 3;
	localparam int IDX_W    = 2;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 32;

	// Defaults and fixed limits
	localparam int RING_DEPTH_DEF = 4;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX_MV    = 16'd3700;
	localparam logic [MV_W-1:0]     STEP_LIMIT_RESET = 12'd200;
	localparam logic [MV_W-1:0]     LOWEST_RESET     = 12'd4095;

	// Battery states
	localparam logic [STATE_W-1:0] ST_GOOD = 2'd0;
	localparam logic [STATE_W-1:0] ST_LOW  = 2'd1;
	localparam logic [STATE_W-1:0] ST_DEAD = 2'd2;

	// Event codes
	localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
	localparam logic [EVENT_W-1:0] EV_LOW    = 3'd1;
	localparam logic [EVENT_W-1:0] EV_DEAD   = 3'd2;
	localparam logic [EVENT_W-1:0] EV_REJECT = 3'd3;
	localparam logic [EVENT_W-1:0] EV_IDLE   = 3'd4;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_WARNING_LEVEL = 2'd0;
	localparam logic [IDX_W-1:0] REG_STANDBY_LEVEL = 2'd1;
	localparam logic [IDX_W-1:0] REG_WARNING_EVERY = 2'd2;
	localparam logic [IDX_W-1:0] REG_STEP_LIMIT    = 2'd3;

endpackage

### src/battery_level_monitor_top.sv
// Battery level monitor: ring average, bit-serial divider and GOOD/LOW/DEAD tracking.
//
// One millivolt sample per input word, one status word per sample. A sample taken
// while both the warning and standby levels are zero, or one above 3700 mV, is
// answered with the current state. A valid sample is slew-limited against the
// present average and written into the ring; the ring is then walked one entry
// per cycle up to the first empty entry, and the new average comes out of a
// restoring divider that retires one quotient bit per cycle. One sample is worked
// on at a time; a finished word waits in the output register while the next
// sample is taken.
module battery_level_monitor_top #(
	parameter int RING_DEPTH = blm_pkg::RING_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port
	input  logic                        wr_en,
	input  logic [blm_pkg::IDX_W-1:0]   wr_index,
	input  logic [blm_pkg::MV_W-1:0]    wr_data,
	// Sample stream; tdata: sample_mv[15:0]
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [blm_pkg::IN_W-1:0]    s_tdata,
	// Status stream; tdata: level_state[1:0], event_res[4:2], average_mv[16:5],
	// lowest_average_mv[28:17], zero[31:29]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [blm_pkg::OUT_W-1:0]   m_tdata
);
	import blm_pkg::*;

	localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = MV_W + $clog2(RING_DEPTH);
	localparam int BIT_W  = $clog2(SUM_W);
	localparam int PAD_W  = OUT_W - STATE_W - EVENT_W - 2 * MV_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SUM  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]          fsm_q;
	logic [MV_W-1:0]     warning_level_q;
	logic [MV_W-1:0]     standby_level_q;
	logic [EVERY_W-1:0]  warning_every_q;
	logic [MV_W-1:0]     step_limit_q;

	logic [MV_W-1:0]     ring_q [RING_DEPTH];
	logic [SLOT_W-1:0]   slot_q;
	logic [STATE_W-1:0]  bstate_q;
	logic [EVERY_W-1:0]  wcount_q;
	logic [MV_W-1:0]     lowest_q;
	logic [MV_W-1:0]     avg_q;

	logic                pass_q;
	logic [EVENT_W-1:0]  ev_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    n_q;
	logic [SUM_W-1:0]    dvd_q;
	logic [CNT_W-1:0]    rem_q;
	logic [BIT_W-1:0]    bit_q;

	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic                accept;
	logic                out_free;
	logic                is_idle;
	logic                is_reject;
	logic [MV_W:0]       hi_lim;
	logic [MV_W-1:0]     lo_lim;
	logic [MV_W-1:0]     clamped;
	logic                walk_more;
	logic [MV_W-1:0]     walk_entry;
	logic [CNT_W:0]      rem_sh;
	logic                rem_ge;
	logic [SUM_W-1:0]    dvd_next;

	logic [STATE_W-1:0]  nstate;
	logic [EVENT_W-1:0]  nev;
	logic [EVERY_W-1:0]  nwcount;
	logic [MV_W-1:0]     nlowest;
	logic                to_low;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (fsm_q == S_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign is_idle   = (warning_level_q == '0) && (standby_level_q == '0);
	assign is_reject = (s_tdata > SAMPLE_MAX_MV);

	// Slew-limit the sample against the present average, lower bound saturates at zero
	always_comb begin
		hi_lim = {1'b0, avg_q} + {1'b0, step_limit_q};
		lo_lim = (avg_q > step_limit_q) ? (avg_q - step_limit_q) : '0;
		clamped = s_tdata[MV_W-1:0];
		if (avg_q != '0) begin
			if (s_tdata > {{(SAMPLE_W-MV_W-1){1'b0}}, hi_lim}) begin
				clamped = hi_lim[MV_W-1:0];
			end else if (s_tdata < {{(SAMPLE_W-MV_W){1'b0}}, lo_lim}) begin
				clamped = lo_lim;
			end
		end
	end

	// Walk the ring up to the first empty entry
	assign walk_entry = ring_q[cnt_q[SLOT_W-1:0]];
	assign walk_more  = (cnt_q < CNT_W'(RING_DEPTH)) && (walk_entry != '0);

	// Restoring divider step: one quotient bit per cycle
	assign rem_sh   = {rem_q, dvd_q[SUM_W-1]};
	assign rem_ge   = (rem_sh >= {1'b0, n_q});
	assign dvd_next = {dvd_q[SUM_W-2:0], rem_ge};

	// Apply standby and warning thresholds to the new average
	always_comb begin
		nstate  = bstate_q;
		nev     = EV_NONE;
		nwcount = wcount_q;
		nlowest = lowest_q;
		to_low  = 1'b0;
		if (bstate_q == ST_DEAD) begin
			nev = EV_DEAD;
		end else begin
			if (bstate_q == ST_GOOD) begin
				if (avg_q < standby_level_q) begin
					nstate = ST_DEAD;
					nev    = EV_DEAD;
				end else if (avg_q < warning_level_q) begin
					nstate = ST_LOW;
					to_low = 1'b1;
				end
			end else begin
				to_low = 1'b1;
			end
			if (to_low) begin
				nwcount = wcount_q + 1'b1;
				if (lowest_q > avg_q) begin
					nlowest = avg_q;
				end
				if (avg_q < standby_level_q) begin
					nstate = ST_DEAD;
					nev    = EV_DEAD;
				end else if (avg_q < warning_level_q) begin
					if (nwcount >= warning_every_q) begin
						nwcount = '0;
						nev     = EV_LOW;
					end
				end else begin
					nstate  = ST_GOOD;
					nwcount = '0;
				end
			end
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warning_level_q <= '0;
			standby_level_q <= '0;
			warning_every_q <= '0;
			step_limit_q    <= STEP_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WARNING_LEVEL: warning_level_q <= wr_data;
				REG_STANDBY_LEVEL: standby_level_q <= wr_data;
				REG_WARNING_EVERY: warning_every_q <= wr_data[EVERY_W-1:0];
				REG_STEP_LIMIT:    step_limit_q    <= wr_data;
			endcase
		end
	end

	// Sequence one sample: write ring, sum, divide, decide; idle or rejected samples go straight to output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= S_IDLE;
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			slot_q     <= '0;
			bstate_q   <= ST_GOOD;
			wcount_q   <= '0;
			lowest_q   <= LOWEST_RESET;
			avg_q      <= '0;
			pass_q     <= 1'b0;
			ev_q       <= EV_NONE;
			sum_q      <= '0;
			cnt_q      <= '0;
			n_q        <= '0;
			dvd_q      <= '0;
			rem_q      <= '0;
			bit_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// Raise the status word when loaded, drop it once taken
			if ((fsm_q == S_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (fsm_q)
				S_IDLE: begin
					if (accept) begin
						if (is_idle || is_reject) begin
							pass_q <= 1'b1;
							ev_q   <= is_idle ? EV_IDLE : EV_REJECT;
							fsm_q  <= S_OUT;
						end else begin
							pass_q         <= 1'b0;
							ring_q[slot_q] <= clamped;
							slot_q         <= (slot_q == SLOT_W'(RING_DEPTH - 1)) ?
								'0 : slot_q + 1'b1;
							sum_q          <= '0;
							cnt_q          <= '0;
							fsm_q          <= S_SUM;
						end
					end
				end
				S_SUM: begin
					if (walk_more) begin
						sum_q <= sum_q + {{(SUM_W-MV_W){1'b0}}, walk_entry};
						cnt_q <= cnt_q + 1'b1;
					end else begin
						dvd_q <= sum_q;
						rem_q <= '0;
						n_q   <= cnt_q;
						bit_q <= BIT_W'(SUM_W - 1);
						fsm_q <= S_DIV;
					end
				end
				S_DIV: begin
					dvd_q <= dvd_next;
					rem_q <= rem_ge ? CNT_W'(rem_sh - {1'b0, n_q}) : rem_sh[CNT_W-1:0];
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						avg_q <= (n_q == '0) ? '0 : dvd_next[MV_W-1:0];
						fsm_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						fsm_q      <= S_IDLE;
						if (pass_q) begin
							m_tdata_q <= {{PAD_W{1'b0}}, lowest_q, avg_q, ev_q, bstate_q};
						end else begin
							bstate_q  <= nstate;
							wcount_q  <= nwcount;
							lowest_q  <= nlowest;
							m_tdata_q <= {{PAD_W{1'b0}}, nlowest, avg_q, nev, nstate};
						end
					end
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_dead_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(bstate_q == ST_DEAD) |=> (bstate_q == ST_DEAD))
		else $error("dead state was left without reset");

	a_word_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(fsm_q) == S_OUT))
		else $error("status word loaded outside the output step");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fsm_q == S_SUM) |-> (cnt_q <= CNT_W'(RING_DEPTH)))
		else $error("ring walk ran past the ring depth");

	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		{4'b0, avg_q} <= SAMPLE_MAX_MV)
		else $error("average above the largest stored sample");

	// The new average lands in the divide step, before the minimum is updated in the output step
	a_lowest_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		((bstate_q == ST_LOW) && (fsm_q != S_OUT)) |-> (lowest_q <= avg_q))
		else $error("lowest average above the present average while low");
`endif

endmodule
